// ----- rtl/core/cdl_pkg.sv -----
// Shared types and constants for the declaration lexer.
// No dependencies; imported by every module of the block.
package cdl_pkg;

  localparam int CHAR_W         = 8;
  localparam int TOKEN_KIND_W   = 4;
  localparam int TOKEN_START_W  = 10;
  localparam int TOKEN_LENGTH_W = 11;

  localparam int BUNDLE_MAX = 3;
  localparam int COUNT_W    = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [TOKEN_KIND_W-1:0] KIND_NUMBER  = 4'd0;
  localparam logic [TOKEN_KIND_W-1:0] KIND_TYPE    = 4'd1;
  localparam logic [TOKEN_KIND_W-1:0] KIND_IDENT   = 4'd2;
  localparam logic [TOKEN_KIND_W-1:0] KIND_STAR    = 4'd3;
  localparam logic [TOKEN_KIND_W-1:0] KIND_AMP     = 4'd4;
  localparam logic [TOKEN_KIND_W-1:0] KIND_COMMA   = 4'd5;
  localparam logic [TOKEN_KIND_W-1:0] KIND_LSQUARE = 4'd6;
  localparam logic [TOKEN_KIND_W-1:0] KIND_RSQUARE = 4'd7;
  localparam logic [TOKEN_KIND_W-1:0] KIND_LPAREN  = 4'd8;
  localparam logic [TOKEN_KIND_W-1:0] KIND_RPAREN  = 4'd9;
  localparam logic [TOKEN_KIND_W-1:0] KIND_END     = 4'd10;
  localparam logic [TOKEN_KIND_W-1:0] KIND_BAD     = 4'd11;

  localparam logic [CHAR_W-1:0] CH_STAR    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_AMP     = 8'h26;
  localparam logic [CHAR_W-1:0] CH_COMMA   = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_LSQUARE = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_RSQUARE = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_UNDER   = 8'h5F;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;

  // keyword table: void int short float double char, zero padded
  localparam int NUM_KW   = 6;
  localparam int KW_SLOTS = 8;
  localparam int KW_IDX_W = 3;

  localparam logic [CHAR_W-1:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
    '{"v", "o", "i", "d", 8'd0, 8'd0, 8'd0, 8'd0},
    '{"i", "n", "t", 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
    '{"s", "h", "o", "r", "t", 8'd0, 8'd0, 8'd0},
    '{"f", "l", "o", "a", "t", 8'd0, 8'd0, 8'd0},
    '{"d", "o", "u", "b", "l", "e", 8'd0, 8'd0},
    '{"c", "h", "a", "r", 8'd0, 8'd0, 8'd0, 8'd0}
  };
  localparam logic [KW_IDX_W-1:0] KW_LEN [NUM_KW] = '{3'd4, 3'd3, 3'd5, 3'd5, 3'd6, 3'd4};

  typedef struct packed {
    logic [TOKEN_KIND_W-1:0]   kind;
    logic [TOKEN_START_W-1:0]  start;
    logic [TOKEN_LENGTH_W-1:0] length;
  } token_t;

  // all tokens caused by one character, oldest in slot 0
  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    token_t [BUNDLE_MAX-1:0]      tok;
  } bundle_t;

endpackage

// ----- rtl/core/cdl_front.sv -----
// Front end: holds the lexer state, classifies one character per cycle while take is high
// and builds the bundle of tokens it completes. Uses cdl_pkg.
module cdl_front
  import cdl_pkg::*;
#(
  parameter int LINE_MAX = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [CHAR_W-1:0] ch,
  input  logic              line_end,
  output bundle_t           bundle,
  output logic              has_result
);

  localparam int POS_W = $clog2(LINE_MAX);
  localparam int LEN_W = POS_W + 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

  typedef enum logic [1:0] {MODE_IDLE, MODE_NUMBER, MODE_WORD} mode_t;

  mode_t             mode_r, mode_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  beg_r, beg_nxt;
  logic [NUM_KW-1:0] hits_r, hits_nxt;

  function automatic logic [NUM_KW-1:0] match_hits(input logic [NUM_KW-1:0] hits,
                                                   input logic [POS_W-1:0]  idx,
                                                   input logic [CHAR_W-1:0] c);
    logic [NUM_KW-1:0] r;
    r = '0;
    for (int k = 0; k < NUM_KW; k++) begin
      r[k] = hits[k] && (idx < {{(POS_W-KW_IDX_W){1'b0}}, KW_LEN[k]}) &&
             (KW_TEXT[k][idx[KW_IDX_W-1:0]] == c);
    end
    return r;
  endfunction

  function automatic logic [TOKEN_KIND_W-1:0] close_kind(input mode_t m,
                                                         input logic [NUM_KW-1:0] hits,
                                                         input logic [LEN_W-1:0] len);
    logic [TOKEN_KIND_W-1:0] kd;
    kd = KIND_NUMBER;
    if (m == MODE_WORD) begin
      kd = KIND_IDENT;
      for (int k = 0; k < NUM_KW; k++) begin
        if (hits[k] && (len == {{(LEN_W-KW_IDX_W){1'b0}}, KW_LEN[k]})) kd = KIND_TYPE;
      end
    end
    return kd;
  endfunction

  function automatic token_t make_tok(input logic [TOKEN_KIND_W-1:0] kd,
                                      input logic [POS_W-1:0] st,
                                      input logic [LEN_W-1:0] len);
    token_t t;
    logic [POS_W+TOKEN_START_W-1:0]  st_ext;
    logic [LEN_W+TOKEN_LENGTH_W-1:0] len_ext;
    st_ext   = {{TOKEN_START_W{1'b0}}, st};
    len_ext  = {{TOKEN_LENGTH_W{1'b0}}, len};
    t.kind   = kd;
    t.start  = st_ext[TOKEN_START_W-1:0];
    t.length = len_ext[TOKEN_LENGTH_W-1:0];
    return t;
  endfunction

  logic is_space, is_digit, is_alpha, consumed, open0, open1;
  logic [POS_W-1:0]        idx, idx1, end_pos;
  logic [TOKEN_KIND_W-1:0] mark_kind;
  token_t tok_a, tok_bc, tok_d;
  logic   v_a, v_mark, v_bc;

  assign is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign is_digit = (ch >= "0") && (ch <= "9");
  assign is_alpha = ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z"));
  assign consumed = ((mode_r == MODE_NUMBER) && is_digit) ||
                    ((mode_r == MODE_WORD) && (is_alpha || is_digit || (ch == CH_UNDER)));
  assign open0    = (mode_r != MODE_IDLE);
  assign idx      = pos_r - beg_r;
  assign end_pos  = (pos_r < POS_LAST) ? pos_r + POS_W'(1) : POS_LAST;

  always_comb begin
    unique case (ch)
      CH_STAR:    mark_kind = KIND_STAR;
      CH_AMP:     mark_kind = KIND_AMP;
      CH_COMMA:   mark_kind = KIND_COMMA;
      CH_LSQUARE: mark_kind = KIND_LSQUARE;
      CH_RSQUARE: mark_kind = KIND_RSQUARE;
      CH_LPAREN:  mark_kind = KIND_LPAREN;
      CH_RPAREN:  mark_kind = KIND_RPAREN;
      default:    mark_kind = KIND_BAD;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    beg_nxt  = beg_r;
    hits_nxt = hits_r;
    v_mark   = 1'b0;
    if (consumed) begin
      if (mode_r == MODE_WORD) hits_nxt = match_hits(hits_r, idx, ch);
    end else if (is_space) begin
      mode_nxt = MODE_IDLE;
    end else if (is_digit) begin
      mode_nxt = MODE_NUMBER;
      beg_nxt  = pos_r;
    end else if (is_alpha) begin
      mode_nxt = MODE_WORD;
      beg_nxt  = pos_r;
      hits_nxt = match_hits('1, '0, ch);
    end else begin
      mode_nxt = MODE_IDLE;
      v_mark   = 1'b1;
    end
  end

  assign v_a   = open0 && !consumed;
  assign tok_a = make_tok(close_kind(mode_r, hits_r, {1'b0, idx}), beg_r, {1'b0, idx});

  assign open1  = (mode_nxt != MODE_IDLE) && line_end;
  assign idx1   = pos_r - beg_nxt;
  assign v_bc   = v_mark || open1;
  assign tok_bc = v_mark ? make_tok(mark_kind, pos_r, LEN_W'(1))
                         : make_tok(close_kind(mode_nxt, hits_nxt, {1'b0, idx1} + LEN_W'(1)),
                                    beg_nxt, {1'b0, idx1} + LEN_W'(1));
  assign tok_d  = make_tok(KIND_END, end_pos, '0);

  always_comb begin
    bundle.count  = COUNT_W'(v_a) + COUNT_W'(v_bc) + COUNT_W'(line_end);
    bundle.tok[2] = tok_d;
    bundle.tok[1] = (v_a && v_bc) ? tok_bc : tok_d;
    bundle.tok[0] = v_a ? tok_a : (v_bc ? tok_bc : tok_d);
  end

  assign has_result = v_a || v_bc || line_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
      beg_r  <= '0;
      hits_r <= '1;
    end else if (take) begin
      if (line_end) begin
        mode_r <= MODE_IDLE;
        pos_r  <= '0;
        beg_r  <= '0;
        hits_r <= '1;
      end else begin
        mode_r <= mode_nxt;
        pos_r  <= pos_nxt;
        beg_r  <= beg_nxt;
        hits_r <= hits_nxt;
      end
    end
  end

  assign pos_nxt = (pos_r < POS_LAST) ? pos_r + POS_W'(1) : pos_r;

endmodule

// ----- rtl/core/cdl_queue.sv -----
// Short queue of token bundles between front and back ends.
// Uses cdl_pkg for the bundle type and depth.
module cdl_queue
  import cdl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output bundle_t head,
  output logic    empty
);

  bundle_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     cnt_r;

  assign full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QPTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- rtl/core/cdl_back.sv -----
// Back end: hands out the tokens of the head bundle one per pop and
// retires the bundle after its last token. Uses cdl_pkg.
module cdl_back
  import cdl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  bundle_t                   head,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      empty,
  output logic [TOKEN_KIND_W-1:0]   token_kind,
  output logic [TOKEN_START_W-1:0]  token_start,
  output logic [TOKEN_LENGTH_W-1:0] token_length,
  output logic                      last
);

  logic [COUNT_W-1:0] idx_r;
  token_t             cur;
  logic               take;

  assign cur          = head.tok[idx_r];
  assign empty        = q_empty;
  assign token_kind   = cur.kind;
  assign token_start  = cur.start;
  assign token_length = cur.length;
  assign last         = (idx_r == head.count - COUNT_W'(1));
  assign take         = pop && !q_empty;
  assign q_pop        = take && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (take) begin
      idx_r <= last ? '0 : idx_r + COUNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/c_declaration_lexer_top.sv -----
// Top level of the declaration lexer: front end, bundle queue, back end.
// Depends on cdl_pkg, cdl_front, cdl_queue and cdl_back.
//
// One character is taken per cycle while in_full is low; each character
// yields zero to three tokens (a token it closes, a mark or bad token or,
// on the last character of a line, the token still open, and End), which
// the output side hands out one per cycle while out_pop is high. The front
// end has no internal stall; in_full rises only when the four-entry bundle
// queue holds the tokens of four characters, so the sustained input rate
// is one character per cycle unless the consumer pops slower than tokens
// are produced. Offsets count from zero at the start of each line and
// saturate at LINE_MAX-1.
module c_declaration_lexer_top
  import cdl_pkg::*;
#(
  parameter int LINE_MAX = 1024
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [CHAR_W-1:0]         in_ch,
  input  logic                      in_line_end,
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [TOKEN_KIND_W-1:0]   out_token_kind,
  output logic [TOKEN_START_W-1:0]  out_token_start,
  output logic [TOKEN_LENGTH_W-1:0] out_token_length,
  output logic                      out_last
);

  logic    take, has_result, q_pop, q_empty;
  bundle_t bundle, head;

  assign take = in_push && !in_full;

  cdl_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .ch         (in_ch),
    .line_end   (in_line_end),
    .bundle     (bundle),
    .has_result (has_result)
  );

  cdl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && has_result),
    .push_data (bundle),
    .full      (in_full),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty)
  );

  cdl_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .pop          (out_pop),
    .empty        (out_empty),
    .token_kind   (out_token_kind),
    .token_start  (out_token_start),
    .token_length (out_token_length),
    .last         (out_last)
  );

endmodule

// ----- bench/tb.sv -----
// Testbench for c_declaration_lexer_top: character items in, token items out.
// Depends on cdl_pkg and the lexer RTL; a token tracker class predicts and checks
// every token, plain tasks drive the input handshake and an initial block the pops.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cdl_pkg::*;

  localparam int LINE_MAX     = 1024;
  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_CYCLES  = 400;

  typedef logic [CHAR_W-1:0] char_q_t[$];

  typedef struct {
    logic [TOKEN_KIND_W-1:0]   kind;
    logic [TOKEN_START_W-1:0]  start;
    logic [TOKEN_LENGTH_W-1:0] length;
    logic                      last;
  } lex_token_t;

  typedef enum int {SCAN_IDLE, SCAN_NUMBER, SCAN_WORD} scan_mode_e;

  class token_tracker;
    string kw_names[NUM_KW] = '{"void", "int", "short", "float", "double", "char"};
    scan_mode_e        mode;
    int                pos;
    int                tok_begin;
    logic [NUM_KW-1:0] kw_hits;
    lex_token_t        awaited[$];
    lex_token_t        fresh[$];
    int                mismatches;
    int                tokens_checked;

    function new();
      mode = SCAN_IDLE;
      pos = 0;
      tok_begin = 0;
      kw_hits = '1;
      mismatches = 0;
      tokens_checked = 0;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    function bit is_space(logic [CHAR_W-1:0] c);
      return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit is_digit(logic [CHAR_W-1:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [CHAR_W-1:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function logic [TOKEN_KIND_W-1:0] mark_kind(logic [CHAR_W-1:0] c);
      case (c)
        CH_STAR:    return KIND_STAR;
        CH_AMP:     return KIND_AMP;
        CH_COMMA:   return KIND_COMMA;
        CH_LSQUARE: return KIND_LSQUARE;
        CH_RSQUARE: return KIND_RSQUARE;
        CH_LPAREN:  return KIND_LPAREN;
        CH_RPAREN:  return KIND_RPAREN;
        default:    return KIND_BAD;
      endcase
    endfunction

    function logic [NUM_KW-1:0] match_kw(logic [NUM_KW-1:0] hits, int idx,
                                         logic [CHAR_W-1:0] c);
      logic [NUM_KW-1:0] r;
      r = '0;
      for (int k = 0; k < NUM_KW; k++)
        if (hits[k] && idx < kw_names[k].len() && kw_names[k][idx] == c) r[k] = 1'b1;
      return r;
    endfunction

    function void emit(logic [TOKEN_KIND_W-1:0] kind, int start, int len);
      lex_token_t t;
      t.kind   = kind;
      t.start  = start[TOKEN_START_W-1:0];
      t.length = len[TOKEN_LENGTH_W-1:0];
      t.last   = 1'b0;
      fresh.push_back(t);
    endfunction

    function void close_token(int len);
      logic [TOKEN_KIND_W-1:0] kind;
      kind = KIND_NUMBER;
      if (mode == SCAN_WORD) begin
        kind = KIND_IDENT;
        for (int k = 0; k < NUM_KW; k++)
          if (kw_hits[k] && kw_names[k].len() == len) kind = KIND_TYPE;
      end
      emit(kind, tok_begin, len);
      mode = SCAN_IDLE;
    endfunction

    // one accepted character: advance the lexer and queue the tokens it yields
    function void note_char(logic [CHAR_W-1:0] c, logic last);
      int p;
      int end_pos;
      bit consumed;
      p = pos;
      consumed = 1'b0;
      fresh.delete();
      if (mode == SCAN_NUMBER && is_digit(c)) begin
        consumed = 1'b1;
      end else if (mode == SCAN_WORD && (is_alpha(c) || is_digit(c) || c == CH_UNDER)) begin
        kw_hits = match_kw(kw_hits, p - tok_begin, c);
        consumed = 1'b1;
      end else if (mode != SCAN_IDLE) begin
        close_token(p - tok_begin);
      end
      if (!consumed && !is_space(c)) begin
        if (is_digit(c)) begin
          mode = SCAN_NUMBER;
          tok_begin = p;
        end else if (is_alpha(c)) begin
          mode = SCAN_WORD;
          tok_begin = p;
          kw_hits = match_kw('1, 0, c);
        end else begin
          emit(mark_kind(c), p, 1);
        end
      end
      if (last) begin
        end_pos = (p + 1 < LINE_MAX - 1) ? p + 1 : LINE_MAX - 1;
        if (mode != SCAN_IDLE) close_token(p - tok_begin + 1);
        emit(KIND_END, end_pos, 0);
        mode = SCAN_IDLE;
        pos = 0;
        tok_begin = 0;
        kw_hits = '1;
      end else if (p < LINE_MAX - 1) begin
        pos = p + 1;
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) awaited.push_back(fresh[i]);
    endfunction

    function void check_token(logic [TOKEN_KIND_W-1:0] kind, logic [TOKEN_START_W-1:0] start,
                              logic [TOKEN_LENGTH_W-1:0] length, logic last);
      lex_token_t e;
      tokens_checked++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("token %0d unexpected: kind %0d start %0d length %0d last %0d",
                   tokens_checked, kind, start, length, last);
        return;
      end
      e = awaited.pop_front();
      if (e.kind !== kind || e.start !== start || e.length !== length || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"token %0d mismatch: expected kind %0d start %0d length %0d last %0d,",
                    " got kind %0d start %0d length %0d last %0d"},
                   tokens_checked, e.kind, e.start, e.length, e.last,
                   kind, start, length, last);
      end
    endfunction
  endclass

  localparam logic [CHAR_W-1:0] MARKS [7] = '{CH_STAR, CH_AMP, CH_COMMA, CH_LSQUARE,
                                             CH_RSQUARE, CH_LPAREN, CH_RPAREN};

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_push = 1'b0;
  logic                      in_full;
  logic [CHAR_W-1:0]         in_ch = '0;
  logic                      in_line_end = 1'b0;
  logic                      out_pop = 1'b0;
  logic                      out_empty;
  logic [TOKEN_KIND_W-1:0]   out_token_kind;
  logic [TOKEN_START_W-1:0]  out_token_start;
  logic [TOKEN_LENGTH_W-1:0] out_token_length;
  logic                      out_last;

  token_tracker board = new();
  int chars_sent = 0;
  int lines_sent = 0;
  bit burst = 1'b0;

  c_declaration_lexer_top #(.LINE_MAX(LINE_MAX)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_ch            (in_ch),
    .in_line_end      (in_line_end),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_alpha();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return rand_alpha();
    if (r < 62) return 8'("0" + r - 52);
    return CH_UNDER;
  endfunction

  // declaration-like line: keywords and near misses, names, numbers, marks, some noise
  function automatic char_q_t make_line();
    char_q_t line;
    string w;
    int pieces;
    int r;
    int i;
    pieces = $urandom_range(1, 8);
    repeat (pieces) begin
      r = $urandom_range(0, 9);
      if (r < 5) line.push_back(CH_SPACE);
      else if (r < 7) line.push_back(8'($urandom_range(9, 13)));
      r = $urandom_range(0, 99);
      if (r < 45) begin
        w = board.kw_names[$urandom_range(0, NUM_KW - 1)];
        if (r >= 30) begin
          case ($urandom_range(0, 3))
            0: w = w.substr(0, w.len() - 2);
            1: w = {w, string'(rand_word_char())};
            2: begin
              i = $urandom_range(0, w.len() - 1);
              w[i] = rand_alpha();
            end
            default: w[0] = w[0] - 8'd32;
          endcase
        end
        for (i = 0; i < w.len(); i++) line.push_back(w[i]);
      end else if (r < 60) begin
        line.push_back(rand_alpha());
        repeat ($urandom_range(0, 7)) line.push_back(rand_word_char());
      end else if (r < 75) begin
        repeat ($urandom_range(1, 5)) line.push_back(8'("0" + $urandom_range(0, 9)));
      end else if (r < 95) begin
        line.push_back(MARKS[$urandom_range(0, 6)]);
      end else begin
        line.push_back(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 3) == 0) line.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    return line;
  endfunction

  task automatic idle_for(int n);
    repeat (n) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
  endtask

  task automatic send_char(logic [CHAR_W-1:0] c, logic last);
    @(negedge clk);
    in_push <= 1'b1;
    in_ch <= c;
    in_line_end <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    board.note_char(c, last);
    chars_sent++;
  endtask

  task automatic send_line(char_q_t line);
    for (int i = 0; i < line.size(); i++) begin
      send_char(line[i], i == line.size() - 1);
      if (!burst) idle_for(pick_gap());
    end
    lines_sent++;
  endtask

  task automatic send_text(string s);
    char_q_t line;
    for (int i = 0; i < s.len(); i++) line.push_back(s[i]);
    send_line(line);
  endtask

  task automatic wait_drained();
    idle_for(1);
    while (board.outstanding() > 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      board.check_token(out_token_kind, out_token_start, out_token_length, out_last);
  end

  // result side: random pops, calm stretches, one long hold-off to back up the input
  initial begin
    int gap_left;
    int hold_left;
    bit held;
    bit calm;
    gap_left = 0;
    hold_left = 0;
    held = 1'b0;
    calm = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) calm = !calm;
      if (!held && board.tokens_checked >= 80) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (!calm) gap_left = pick_gap();
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle = 0;
      else idle++;
    end
    $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
    $display("[c_declaration_lexer_top] ERROR");
    $finish;
  end

  initial begin
    int random_chars;
    bit long_done;
    char_q_t line;
    random_chars = 0;
    long_done = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every token kind, bad bytes, underscore at word start, trailing whitespace
    send_text("int *p[1],&q(x);");
    send_text("_a_9\t");
    send_text("7");
    line = '{8'hFF, 8'h80, 8'h00, 8'h7F};
    send_line(line);
    wait_drained();
    idle_for(4);

    while (random_chars < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 3) == 0);
      line = make_line();
      send_line(line);
      random_chars += line.size();
      if (!long_done && random_chars > 200) begin
        // line past LINE_MAX: saturated offsets and lengths
        burst = 1'b1;
        line.delete();
        repeat (LINE_MAX + 6) line.push_back("a");
        send_line(line);
        long_done = 1'b1;
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);

    $display("sent %0d characters on %0d lines, checked %0d tokens, %0d mismatches",
             chars_sent, lines_sent, board.tokens_checked, board.mismatches);
    $display("covered all token kinds, keyword near misses, noise bytes and a saturated long line");
    if (board.mismatches == 0) begin
      $display("[c_declaration_lexer_top] OK");
    end else begin
      $display("[c_declaration_lexer_top] ERROR");
    end
    $finish;
  end

endmodule
